>>> rtl/core/tmd_pkg.sv
// tmd_pkg: shared constants, register codes and transfer types of the
// thermal motion detector. No dependencies.
`timescale 1ns / 1ps
package tmd_pkg;

  localparam int FRAME_PIXELS = 19200;
  localparam int POS_W        = $clog2(FRAME_PIXELS);
  localparam int SAMPLE_W     = 16;
  localparam int PIX_W        = 8;
  localparam int GAIN_W       = 12;
  localparam int THR_W        = 8;
  localparam int ACC_W        = 24;
  localparam int PROD_W       = PIX_W + GAIN_W;
  localparam int DECAY_W      = 16;
  localparam int DMUL_W       = ACC_W + DECAY_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [DECAY_W-1:0]  DECAY_Q16  = 16'd55706;
  localparam logic [DMUL_W:0]     DECAY_RND  = 41'd32768;
  localparam logic [PIX_W-1:0]    PIX_MAX    = 8'd255;
  localparam logic [ACC_W-1:0]    ACC_MAX    = 24'hFF_FFFF;
  localparam logic [ACC_W:0]      VAL_RND    = 25'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_RAW_OFFSET       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLIFY_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] RAW_OFFSET_RST = 16'sd1200;
  localparam logic [GAIN_W-1:0]          GAIN_RST       = 12'd1280;
  localparam logic [THR_W-1:0]           THR_RST        = 8'd128;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             have_prev;
    logic             have_acc;
  } pix_item_t;

  typedef struct packed {
    logic motion_pixel;
    logic frame_moved;
    logic last;
  } result_t;

endpackage

>>> rtl/core/tmd_in_if.sv
// tmd_in_if: sample channel (valid/ready plus raw sample and frame end).
// Depends on tmd_pkg.
`timescale 1ns / 1ps
interface tmd_in_if
  import tmd_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] raw_sample;
  logic                       frame_end;

  modport source (output valid, output raw_sample, output frame_end, input ready);
  modport sink   (input valid, input raw_sample, input frame_end, output ready);
endinterface

>>> rtl/core/tmd_out_if.sv
// tmd_out_if: result channel (valid/ready plus motion flags).
// No dependencies.
`timescale 1ns / 1ps
interface tmd_out_if;
  logic valid;
  logic ready;
  logic motion_pixel;
  logic frame_moved;
  logic last;

  modport source (output valid, output motion_pixel, output frame_moved, output last,
                  input ready);
  modport sink   (input valid, input motion_pixel, input frame_moved, input last,
                  output ready);
endinterface

>>> rtl/core/thermal_motion_detector.sv
// thermal_motion_detector: top level, configuration registers and handshakes.
// Depends on tmd_pkg, tmd_in_if, tmd_out_if, tmd_seq, tmd_pipe, tmd_obuf.
//
// Usage:
//   in_ch carries raw 16-bit samples in raster order, frame_end on the last
//   pixel of a frame. out_ch returns one result per sample, in order:
//   motion_pixel, and on the frame's last pixel (last = 1) frame_moved.
//   cfg_we/cfg_index/cfg_data write raw_offset (0), amplify_gain (1) and
//   motion_threshold (2); write only while the block is idle.
//   A result is offered once its sample has passed the three pipe stages and
//   has been written into the result buffer.
//   Throughput: one sample per cycle while the result buffer has space, set
//   by the three pipe stages and the single write port of each frame store.
//   A frame of three pixels or fewer holds in_ch.ready low until the previous
//   write to the same pixel has landed.
//   in_ch.ready comes from registers only; a two-entry result buffer lets a
//   new sample in while a result waits, and the pipe freezes as a whole
//   once the buffer is full, so nothing is lost or repeated.
//   Reset clears position, frame state and the buffer; the frame stores
//   are not cleared and the first frame after reset gives no motion.
`timescale 1ns / 1ps
module thermal_motion_detector
  import tmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tmd_in_if.sink                in_ch,
  tmd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [SAMPLE_W-1:0] raw_offset_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [THR_W-1:0]           thr_r;

  logic      adv, hazard, accept, push, pop, obuf_valid;
  pix_item_t item;
  result_t   pipe_res, obuf_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_offset_r <= RAW_OFFSET_RST;
      gain_r       <= GAIN_RST;
      thr_r        <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAW_OFFSET:       raw_offset_r <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_AMPLIFY_GAIN:     gain_r       <= cfg_data[GAIN_W-1:0];
        CFG_MOTION_THRESHOLD: thr_r        <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = adv && !hazard;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  tmd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .raw_sample (in_ch.raw_sample),
    .frame_end  (in_ch.frame_end),
    .raw_offset (raw_offset_r),
    .item       (item)
  );

  tmd_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .accept           (accept),
    .item             (item),
    .amplify_gain     (gain_r),
    .motion_threshold (thr_r),
    .hazard           (hazard),
    .push             (push),
    .result           (pipe_res)
  );

  tmd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (pipe_res),
    .pop       (pop),
    .out_valid (obuf_valid),
    .dout      (obuf_res),
    .space     (adv)
  );

  assign out_ch.valid        = obuf_valid;
  assign out_ch.motion_pixel = obuf_res.motion_pixel;
  assign out_ch.frame_moved  = obuf_res.frame_moved;
  assign out_ch.last         = obuf_res.last;

endmodule

>>> rtl/core/tmd_seq.sv
// tmd_seq: offset removal and clipping, pixel position and frame state.
// Depends on tmd_pkg.
`timescale 1ns / 1ps
module tmd_seq
  import tmd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] raw_sample,
  input  logic                       frame_end,
  input  logic signed [SAMPLE_W-1:0] raw_offset,
  output pix_item_t                  item
);

  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic                      have_acc_r, have_acc_nxt;
  logic signed [SAMPLE_W:0]  diff;
  logic                      is_last;

  always_comb begin
    diff = {raw_sample[SAMPLE_W-1], raw_sample} - {raw_offset[SAMPLE_W-1], raw_offset};
    is_last = frame_end || (pos_r == POS_W'(FRAME_PIXELS - 1));
    item.pos       = pos_r;
    item.last      = is_last;
    item.have_prev = have_prev_r;
    item.have_acc  = have_acc_r;
    if (diff <= 0) begin
      item.pix = '0;
    end else if (diff >= $signed({1'b0, {(SAMPLE_W-PIX_W){1'b0}}, PIX_MAX})) begin
      item.pix = PIX_MAX;
    end else begin
      item.pix = diff[PIX_W-1:0];
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    have_prev_nxt = have_prev_r;
    have_acc_nxt  = have_acc_r;
    if (accept) begin
      if (is_last) begin
        pos_nxt       = '0;
        have_prev_nxt = 1'b1;
        have_acc_nxt  = have_acc_r | have_prev_r;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      have_prev_r <= 1'b0;
      have_acc_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      have_prev_r <= have_prev_nxt;
      have_acc_r  <= have_acc_nxt;
    end
  end

endmodule

>>> rtl/core/tmd_pipe.sv
// tmd_pipe: frame stores and three-stage difference, decay and threshold pipe.
// Depends on tmd_pkg.
`timescale 1ns / 1ps
module tmd_pipe
  import tmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              accept,
  input  pix_item_t         item,
  input  logic [GAIN_W-1:0] amplify_gain,
  input  logic [THR_W-1:0]  motion_threshold,
  output logic              hazard,
  output logic              push,
  output result_t           result
);

  logic [PIX_W-1:0] prev_mem [FRAME_PIXELS];
  logic [ACC_W-1:0] acc_mem  [FRAME_PIXELS];

  // stage 1: item plus registered store reads
  logic             v1_r;
  pix_item_t        it1_r;
  logic [PIX_W-1:0] prev_q_r;
  logic [ACC_W-1:0] acc_q_r;

  // stage 2: products
  logic              v2_r;
  pix_item_t         it2_r;
  logic [PROD_W-1:0] prod2_r, prod2_nxt;
  logic [DMUL_W-1:0] dmul2_r, dmul2_nxt;
  logic [PIX_W-1:0]  absdiff;

  // stage 3: new accumulator
  logic             v3_r;
  pix_item_t        it3_r;
  logic [ACC_W-1:0] acc3_r, acc3_nxt;
  logic [DMUL_W:0]  dec_full;
  logic [ACC_W:0]   acc_sum;

  logic [ACC_W:0]   val_full;
  logic [PIX_W-1:0] val;
  logic             motion;
  logic             moved_r, moved_nxt;

  assign hazard = (v1_r && it1_r.pos == item.pos) || (v2_r && it2_r.pos == item.pos) ||
                  (v3_r && it3_r.pos == item.pos);

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_q_r <= prev_mem[item.pos];
      acc_q_r  <= acc_mem[item.pos];
    end
    if (adv && v3_r) begin
      prev_mem[it3_r.pos] <= it3_r.pix;
    end
    if (adv && v3_r && it3_r.have_prev) begin
      acc_mem[it3_r.pos] <= acc3_r;
    end
  end

  always_comb begin
    absdiff   = (it1_r.pix > prev_q_r) ? it1_r.pix - prev_q_r : prev_q_r - it1_r.pix;
    prod2_nxt = PROD_W'(absdiff) * PROD_W'(amplify_gain);
    dmul2_nxt = DMUL_W'(acc_q_r) * DMUL_W'(DECAY_Q16);
  end

  always_comb begin
    dec_full = {1'b0, dmul2_r} + DECAY_RND;
    acc_sum  = dec_full[DMUL_W:DECAY_W] + (ACC_W+1)'(prod2_r);
    if (!it2_r.have_acc) begin
      acc3_nxt = ACC_W'(prod2_r);
    end else if (acc_sum[ACC_W]) begin
      acc3_nxt = ACC_MAX;
    end else begin
      acc3_nxt = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    val_full = {1'b0, acc3_r} + VAL_RND;
    val      = (|val_full[ACC_W:2*PIX_W]) ? PIX_MAX : val_full[2*PIX_W-1:PIX_W];
    motion   = it3_r.have_prev && (val > motion_threshold);
    push     = adv && v3_r;
    result.motion_pixel = motion;
    result.frame_moved  = it3_r.last && (moved_r || motion);
    result.last         = it3_r.last;
    moved_nxt = moved_r;
    if (push) begin
      moved_nxt = it3_r.last ? 1'b0 : (moved_r || motion);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      moved_r <= 1'b0;
    end else begin
      moved_r <= moved_nxt;
      if (adv) begin
        v1_r <= accept;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r   <= item;
      it2_r   <= it1_r;
      prod2_r <= prod2_nxt;
      dmul2_r <= dmul2_nxt;
      it3_r   <= it2_r;
      acc3_r  <= acc3_nxt;
    end
  end

endmodule

>>> rtl/core/tmd_obuf.sv
// tmd_obuf: two-entry result buffer between the pipe and the result channel.
// Depends on tmd_pkg.
`timescale 1ns / 1ps
module tmd_obuf
  import tmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t din,
  input  logic    pop,
  output logic    out_valid,
  output result_t dout,
  output logic    space
);

  result_t    buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2);
  assign dout      = buf_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule

>>> rtl/core/tmd_checker.sv
// tmd_checker: port-level checks on the thermal motion detector, bound to
// the top level. Depends on thermal_motion_detector.
`timescale 1ns / 1ps
module tmd_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_motion_pixel,
  input logic out_frame_moved,
  input logic out_last
);

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // frame flag only on a frame's last result
  a_moved_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_moved |-> out_last)
    else $error("frame_moved without last");

  // a stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last) &&
    $stable(out_motion_pixel) && $stable(out_frame_moved))
    else $error("stalled result dropped or changed");

endmodule

bind thermal_motion_detector tmd_checker u_tmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_motion_pixel (out_ch.motion_pixel),
  .out_frame_moved  (out_ch.frame_moved),
  .out_last         (out_ch.last)
);
